[rtl/core/sha256_hash_engine_unit_macros.svh]
// Assertion macros for the hash engine
`ifndef SHA256_HASH_ENGINE_UNIT_MACROS_SVH
`define SHA256_HASH_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha256 check failed");
`define SHA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha256 check failed");
`else
`define SHA_ASSERT_IMP(lbl, ante, cons)
`define SHA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/core/sha_pkg.sv]
package sha_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  // One message word on its way from packer to compressor
  typedef struct packed {
    logic [31:0] word;
    logic        blk_end;
    logic        msg_end;
  } q_entry_t;

  // Queue status seen by the packer
  typedef struct packed {
    logic full;
  } q_stat_t;

  function automatic logic [31:0] sha_iv(input logic [2:0] i);
    logic [31:0] v;
    case (i)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      3'd7: v = 32'h5be0cd19;
      default: v = 32'h6a09e667;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sha_k(input logic [5:0] i);
    logic [31:0] v;
    case (i)
      6'd0:  v = 32'h428a2f98; 6'd1:  v = 32'h71374491; 6'd2:  v = 32'hb5c0fbcf;
      6'd3:  v = 32'he9b5dba5; 6'd4:  v = 32'h3956c25b; 6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4; 6'd7:  v = 32'hab1c5ed5; 6'd8:  v = 32'hd807aa98;
      6'd9:  v = 32'h12835b01; 6'd10: v = 32'h243185be; 6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74; 6'd13: v = 32'h80deb1fe; 6'd14: v = 32'h9bdc06a7;
      6'd15: v = 32'hc19bf174; 6'd16: v = 32'he49b69c1; 6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6; 6'd19: v = 32'h240ca1cc; 6'd20: v = 32'h2de92c6f;
      6'd21: v = 32'h4a7484aa; 6'd22: v = 32'h5cb0a9dc; 6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152; 6'd25: v = 32'ha831c66d; 6'd26: v = 32'hb00327c8;
      6'd27: v = 32'hbf597fc7; 6'd28: v = 32'hc6e00bf3; 6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351; 6'd31: v = 32'h14292967; 6'd32: v = 32'h27b70a85;
      6'd33: v = 32'h2e1b2138; 6'd34: v = 32'h4d2c6dfc; 6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354; 6'd37: v = 32'h766a0abb; 6'd38: v = 32'h81c2c92e;
      6'd39: v = 32'h92722c85; 6'd40: v = 32'ha2bfe8a1; 6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70; 6'd43: v = 32'hc76c51a3; 6'd44: v = 32'hd192e819;
      6'd45: v = 32'hd6990624; 6'd46: v = 32'hf40e3585; 6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116; 6'd49: v = 32'h1e376c08; 6'd50: v = 32'h2748774c;
      6'd51: v = 32'h34b0bcb5; 6'd52: v = 32'h391c0cb3; 6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f; 6'd55: v = 32'h682e6ff3; 6'd56: v = 32'h748f82ee;
      6'd57: v = 32'h78a5636f; 6'd58: v = 32'h84c87814; 6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa; 6'd61: v = 32'ha4506ceb; 6'd62: v = 32'hbef9a3f7;
      6'd63: v = 32'hc67178f2;
      default: v = 32'h428a2f98;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/sha_front.sv]
module sha_front import sha_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_byte_present,
  input  logic       in_end_of_message,
  input  q_stat_t    q_stat,
  output logic       q_push,
  output q_entry_t   q_data
);

  typedef enum logic [4:0] {
    F_ACCEPT = 5'b00001,
    F_MARK   = 5'b00010,
    F_ZERO   = 5'b00100,
    F_LEN_HI = 5'b01000,
    F_LEN_LO = 5'b10000
  } fstate_t;

  fstate_t     state_r, state_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [1:0]  bpos_r, bpos_nxt;
  logic [3:0]  wpos_r, wpos_nxt;
  logic [63:0] len_r, len_nxt;
  logic [31:0] acc_byte, acc_mark;

  assign in_ready = (state_r == F_ACCEPT) && !q_stat.full;

  // Place the incoming byte and the padding marker at the current byte slot
  always_comb begin
    acc_byte = acc_r;
    acc_mark = acc_r;
    case (bpos_r)
      2'd0: begin acc_byte[31:24] = in_data_byte; acc_mark[31:24] = 8'h80; end
      2'd1: begin acc_byte[23:16] = in_data_byte; acc_mark[23:16] = 8'h80; end
      2'd2: begin acc_byte[15:8]  = in_data_byte; acc_mark[15:8]  = 8'h80; end
      2'd3: begin acc_byte[7:0]   = in_data_byte; acc_mark[7:0]   = 8'h80; end
      default: begin acc_byte = acc_r; acc_mark = acc_r; end
    endcase
  end

  // Pack bytes into words, then walk the padding words on end of message
  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    bpos_nxt  = bpos_r;
    wpos_nxt  = wpos_r;
    len_nxt   = len_r;
    q_push    = 1'b0;
    q_data    = '{word: acc_byte, blk_end: (wpos_r == 4'd15), msg_end: 1'b0};
    case (state_r)
      F_ACCEPT: begin
        if (in_valid && in_ready) begin
          if (in_byte_present) begin
            len_nxt = len_r + 64'd8;
            if (bpos_r == 2'd3) begin
              q_push   = 1'b1;
              acc_nxt  = '0;
              bpos_nxt = 2'd0;
              wpos_nxt = wpos_r + 4'd1;
            end else begin
              acc_nxt  = acc_byte;
              bpos_nxt = bpos_r + 2'd1;
            end
          end
          if (in_end_of_message) state_nxt = F_MARK;
        end
      end
      F_MARK: begin
        q_data.word = acc_mark;
        if (!q_stat.full) begin
          q_push    = 1'b1;
          acc_nxt   = '0;
          bpos_nxt  = 2'd0;
          wpos_nxt  = wpos_r + 4'd1;
          state_nxt = (wpos_r == 4'd13) ? F_LEN_HI : F_ZERO;
        end
      end
      F_ZERO: begin
        q_data.word = '0;
        if (!q_stat.full) begin
          q_push   = 1'b1;
          wpos_nxt = wpos_r + 4'd1;
          if (wpos_r == 4'd13) state_nxt = F_LEN_HI;
        end
      end
      F_LEN_HI: begin
        q_data.word = len_r[63:32];
        if (!q_stat.full) begin
          q_push    = 1'b1;
          wpos_nxt  = wpos_r + 4'd1;
          state_nxt = F_LEN_LO;
        end
      end
      F_LEN_LO: begin
        q_data.word    = len_r[31:0];
        q_data.msg_end = 1'b1;
        if (!q_stat.full) begin
          q_push    = 1'b1;
          wpos_nxt  = 4'd0;
          len_nxt   = '0;
          state_nxt = F_ACCEPT;
        end
      end
      default: state_nxt = F_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_ACCEPT;
      acc_r   <= '0;
      bpos_r  <= '0;
      wpos_r  <= '0;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      bpos_r  <= bpos_nxt;
      wpos_r  <= wpos_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

[rtl/core/sha_queue.sv]
module sha_queue import sha_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  output q_stat_t  stat,
  output logic     pop_valid,
  input  logic     pop,
  output q_entry_t pop_data
);

  q_entry_t         mem_r [QDepth];
  logic [QPtrW-1:0] wr_r, rd_r;
  logic [QPtrW:0]   cnt_r;

  assign stat.full = (cnt_r == (QPtrW+1)'(QDepth));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rd_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

[rtl/core/sha_back.sv]
module sha_back import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  q_entry_t    q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_digest_last
);

  typedef enum logic [3:0] {
    B_LOAD  = 4'b0001,
    B_ROUND = 4'b0010,
    B_ADD   = 4'b0100,
    B_OUT   = 4'b1000
  } bstate_t;

  bstate_t     state_r;
  logic [31:0] w_r   [16];
  logic [31:0] st_r  [8];
  logic [31:0] chain_r [8];
  logic [5:0]  rnd_r;
  logic [2:0]  idx_r;
  logic        msg_end_r;
  logic [31:0] w_new, t1, t2, s0, s1, bs0, bs1, ch, mj;
  logic [31:0] a, b, c, d, e, f, g, h;

  assign a = st_r[0]; assign b = st_r[1]; assign c = st_r[2]; assign d = st_r[3];
  assign e = st_r[4]; assign f = st_r[5]; assign g = st_r[6]; assign h = st_r[7];

  // Message schedule and round function
  always_comb begin
    s0    = {w_r[1][6:0], w_r[1][31:7]} ^ {w_r[1][17:0], w_r[1][31:18]} ^ (w_r[1] >> 3);
    s1    = {w_r[14][16:0], w_r[14][31:17]} ^ {w_r[14][18:0], w_r[14][31:19]}
            ^ (w_r[14] >> 10);
    w_new = w_r[0] + s0 + w_r[9] + s1;
    bs1   = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
    ch    = (e & f) ^ (~e & g);
    t1    = h + bs1 + ch + sha_k(rnd_r) + w_r[0];
    bs0   = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
    mj    = (a & b) ^ (a & c) ^ (b & c);
    t2    = bs0 + mj;
  end

  assign q_pop           = (state_r == B_LOAD) && q_valid;
  assign out_valid       = (state_r == B_OUT);
  assign out_digest_word = chain_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_digest_last = (idx_r == 3'd7);

  // Working registers and schedule window
  always_ff @(posedge clk) begin
    case (state_r)
      B_LOAD: begin
        if (q_pop) begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= q_data.word;
          if (q_data.blk_end) begin
            for (int i = 0; i < 8; i++) st_r[i] <= chain_r[i];
            msg_end_r <= q_data.msg_end;
          end
        end
      end
      B_ROUND: begin
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= w_new;
        st_r[7] <= g; st_r[6] <= f; st_r[5] <= e; st_r[4] <= d + t1;
        st_r[3] <= c; st_r[2] <= b; st_r[1] <= a; st_r[0] <= t1 + t2;
      end
      default: begin
      end
    endcase
  end

  // Sequence load, rounds, chaining add and digest output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_LOAD;
      rnd_r   <= '0;
      idx_r   <= '0;
      for (int i = 0; i < 8; i++) chain_r[i] <= sha_iv(3'(i));
    end else begin
      case (state_r)
        B_LOAD: begin
          if (q_pop && q_data.blk_end) begin
            rnd_r   <= '0;
            state_r <= B_ROUND;
          end
        end
        B_ROUND: begin
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) state_r <= B_ADD;
        end
        B_ADD: begin
          for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + st_r[i];
          idx_r   <= '0;
          state_r <= msg_end_r ? B_OUT : B_LOAD;
        end
        B_OUT: begin
          if (out_ready) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              for (int i = 0; i < 8; i++) chain_r[i] <= sha_iv(3'(i));
              state_r <= B_LOAD;
            end
          end
        end
        default: state_r <= B_LOAD;
      endcase
    end
  end

endmodule

[rtl/core/sha256_hash_engine_unit.sv]
// Streaming SHA-256: one byte transaction per cycle while the packer is accepting and the word queue has room.
// Each 64-byte block is loaded as 16 words, then takes 64 rounds plus one chaining add
// in the compressor; the single round unit sets sustained throughput.
// End of message adds up to 2 padding blocks, then 8 digest transactions follow.
// Synchronous active-low reset returns the chaining value to the initial vector.
`include "sha256_hash_engine_unit_macros.svh"
module sha256_hash_engine_unit import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_digest_last
);

  q_stat_t  q_stat;
  q_entry_t q_in, q_out;
  logic     q_push, q_pop, q_valid;

  sha_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data_byte, .in_byte_present,
    .in_end_of_message, .q_stat, .q_push, .q_data(q_in)
  );

  sha_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_data(q_in), .stat(q_stat),
    .pop_valid(q_valid), .pop(q_pop), .pop_data(q_out)
  );

  sha_back u_back (
    .clk, .rst_n, .q_valid, .q_data(q_out), .q_pop, .out_valid, .out_ready,
    .out_digest_word, .out_word_index, .out_digest_last
  );

  `SHA_ASSERT_IMP(a_no_overflow, q_push, !q_stat.full || q_pop)
  `SHA_ASSERT_IMP(a_ready_room, in_ready, !q_stat.full)
  `SHA_ASSERT_NXT(a_index_step, out_valid && out_ready && !out_digest_last,
                  out_valid && (out_word_index == $past(out_word_index) + 3'd1))

endmodule
